[rtl/core/ret_pkg.sv]
// Shared types and constants for the repeat event table.
package ret_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam int unsigned RSP_COUNT_W     = 5;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_RESET  = 3'd2,
      OP_TICK   = 3'd3,
      OP_QUERY  = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  slot;
      logic [15:0] repeat_limit;
      logic [15:0] period;
      logic        stale_in;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic                   accepted;
      logic                   fire;
      logic                   stale_out;
      logic [RSP_COUNT_W-1:0] entries_in_use;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  slot;
      logic [15:0] repeat_limit;
      logic [15:0] repeats_done;
      logic [15:0] period;
      logic [15:0] progress;
      logic        stale;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic shift;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic remove_hit;
      logic shift_done;
   } status_type;

endpackage

[rtl/core/ret_ram.sv]
// Generic simple dual-port RAM with registered read.
module ret_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ret_control.sv]
// Sequencer for the repeat event table: lookup walk, removal shift, finish.
module ret_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ret_pkg::status_type    status,
   output logic                   busy,
   output ret_pkg::cmd_type       cmd
);

   ret_pkg::state_type state_ff;
   ret_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ret_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ret_pkg::ST_SCAN;
            end
         end
         ret_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = status.remove_hit ? ret_pkg::ST_SHIFT : ret_pkg::ST_FINISH;
            end
         end
         ret_pkg::ST_SHIFT: begin
            if (status.shift_done) begin
               state_in = ret_pkg::ST_FINISH;
            end
         end
         ret_pkg::ST_FINISH: begin
            state_in = ret_pkg::ST_IDLE;
         end
         default: begin
            state_in = ret_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ret_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ret_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ret_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ret_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ret_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/ret_datapath.sv]
// Datapath: request register, table walk, entry update and result register.
module ret_datapath #(
   parameter int unsigned ENTRIES = ret_pkg::ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ret_pkg::req_type    req_data,
   input  ret_pkg::cmd_type    cmd,
   output ret_pkg::status_type status,
   output logic                rsp_valid,
   output ret_pkg::rsp_type    rsp_data
);

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned EW = $bits(ret_pkg::entry_type);

   ret_pkg::req_type   req_ff;
   ret_pkg::req_type   req_in;
   ret_pkg::entry_type entry_ff;
   ret_pkg::entry_type entry_in;
   ret_pkg::rsp_type   rsp_ff;
   ret_pkg::rsp_type   rsp_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      walk_addr_ff, walk_addr_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CW-1:0]      used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               rd_en;
   logic [EW-1:0]      rd_raw;
   ret_pkg::entry_type rd_entry;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   ret_pkg::entry_type wr_entry;

   logic               skip_lookup;
   logic               match;
   logic               more;
   logic               full;
   logic [16:0]        next_prog;
   logic               wrap;
   ret_pkg::entry_type ticked;
   logic               tick_fire;

   assign rd_entry    = ret_pkg::entry_type'(rd_raw);
   assign skip_lookup = !(req_ff.opcode inside {ret_pkg::OP_ADD, ret_pkg::OP_REMOVE,
                                                ret_pkg::OP_RESET, ret_pkg::OP_TICK,
                                                ret_pkg::OP_QUERY});
   assign match       = pend_ff && (rd_entry.slot == req_ff.slot);
   assign more        = walk_addr_ff < used_ff;
   assign full        = used_ff == CW'(ENTRIES);

   assign status.scan_done  = skip_lookup || match || (!pend_ff && !more);
   assign status.remove_hit = match && (req_ff.opcode == ret_pkg::OP_REMOVE);
   assign status.shift_done = !pend_ff && !more;

   // tick arithmetic on the captured entry
   always_comb begin
      ticked    = entry_ff;
      tick_fire = 1'b0;
      next_prog = {1'b0, entry_ff.progress} + 17'd1;
      wrap      = next_prog >= {1'b0, entry_ff.period};
      if (wrap) begin
         ticked.progress = '0;
         if (entry_ff.repeat_limit == '0) begin
            tick_fire = 1'b1;
         end else if (entry_ff.repeats_done < entry_ff.repeat_limit) begin
            ticked.repeats_done = entry_ff.repeats_done + 16'd1;
            tick_fire           = 1'b1;
         end
      end else begin
         ticked.progress = next_prog[15:0];
      end
   end

   always_comb begin
      req_in       = req_ff;
      entry_in     = entry_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      walk_addr_in = walk_addr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      used_in      = used_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_entry     = entry_ff;

      if (cmd.load) begin
         req_in       = req_data;
         hit_in       = 1'b0;
         walk_addr_in = '0;
         pend_in      = 1'b0;
      end

      if (cmd.scan && !skip_lookup) begin
         if (match) begin
            hit_in       = 1'b1;
            pos_in       = pend_idx_ff;
            entry_in     = rd_entry;
            pend_in      = 1'b0;
            walk_addr_in = CW'(pend_idx_ff) + CW'(1);
         end else if (more) begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_idx_in  = walk_addr_ff[AW-1:0];
            walk_addr_in = walk_addr_ff + CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end

      // close the gap: each entry read moves down one place
      if (cmd.shift) begin
         if (pend_ff) begin
            wr_en    = 1'b1;
            wr_addr  = pend_idx_ff - AW'(1);
            wr_entry = rd_entry;
         end
         if (more) begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_idx_in  = walk_addr_ff[AW-1:0];
            walk_addr_in = walk_addr_ff + CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_in.found    = hit_ff;
         rsp_in.stale_out = hit_ff && entry_ff.stale;
         rsp_in.accepted = 1'b0;
         rsp_in.fire     = 1'b0;
         case (req_ff.opcode)
            ret_pkg::OP_ADD: begin
               if (!full) begin
                  wr_en                 = 1'b1;
                  wr_addr               = used_ff[AW-1:0];
                  wr_entry.slot         = req_ff.slot;
                  wr_entry.repeat_limit = req_ff.repeat_limit;
                  wr_entry.repeats_done = '0;
                  wr_entry.period       = req_ff.period;
                  wr_entry.progress     = '0;
                  wr_entry.stale        = req_ff.stale_in;
                  used_in               = used_ff + CW'(1);
                  rsp_in.accepted       = 1'b1;
               end
            end
            ret_pkg::OP_REMOVE: begin
               if (hit_ff) begin
                  used_in         = used_ff - CW'(1);
                  rsp_in.accepted = 1'b1;
               end
            end
            ret_pkg::OP_RESET: begin
               if (hit_ff) begin
                  wr_en                 = 1'b1;
                  wr_entry.repeats_done = '0;
                  wr_entry.progress     = '0;
               end
            end
            ret_pkg::OP_TICK: begin
               if (hit_ff && entry_ff.period != '0) begin
                  wr_en       = 1'b1;
                  wr_entry    = ticked;
                  rsp_in.fire = tick_fire;
               end
            end
            ret_pkg::OP_CLEAR: begin
               used_in = '0;
            end
            default: begin
               used_in = used_ff;
            end
         endcase
         rsp_in.entries_in_use = ret_pkg::RSP_COUNT_W'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      entry_ff     <= entry_in;
      pos_ff       <= pos_in;
      walk_addr_ff <= walk_addr_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_ff       <= rsp_in;
   end

   ret_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (walk_addr_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/repeat_event_table_unit.sv]
// Top level of the repeat event table: controller, datapath and checks.
//
// Usage: raise start with a command on req_data while busy is low; the
// transfer happens at that clock edge and busy rises on the next cycle.
// Commands: add, remove, reset counters, tick, query stale and clear, all
// keyed by slot number. Each command gives exactly one result: rsp_valid
// is high for one cycle with rsp_data, and the receiver must take it then,
// since it cannot hold results off.
// Sequence: a command that looks up a slot walks the table one entry per
// cycle through the registered read port of the table RAM, stopping at a
// hit or at the end of the used entries. A remove that hits then shifts
// the later entries down, one entry per cycle on the same RAM. Clear and
// unused opcodes skip the walk and go straight to the finish step.
// The next command may be transferred in the cycle the result is shown.
// Reset: synchronous, active high; the table empties (count to zero) at
// once, entry storage is not cleared and needs no sweep.
module repeat_event_table_unit #(
   parameter int unsigned ENTRIES = ret_pkg::ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ret_pkg::req_type req_data,
   output logic             rsp_valid,
   output ret_pkg::rsp_type rsp_data
);

   ret_pkg::cmd_type    cmd;
   ret_pkg::status_type status;

   // sequencing of walk, shift and finish steps
   ret_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // table storage, comparison and entry update
   ret_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result only appears once the sequencer is back at rest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a command is still in progress");

   // every finish step yields exactly one result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish step produced no result");

   // hold at most one datapath command at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.shift, cmd.finish}))
      else $error("more than one datapath command at once");

   // a transfer always starts work
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("transfer did not start a command");

endmodule
